>>> rtl/lwfc_pkg.sv
package lwfc_pkg;

    // table and word geometry
    localparam int TABLE_DEPTH  = 64;
    localparam int MAX_WORD_LEN = 16;
    localparam int COUNT_WIDTH  = 16;
    localparam int LETTERS      = 26;

    localparam int SLOT_W   = $clog2(TABLE_DEPTH);
    localparam int USED_W   = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W    = $clog2(MAX_WORD_LEN + 1);
    localparam int POS_W    = $clog2(MAX_WORD_LEN);
    localparam int LETTER_W = $clog2(LETTERS);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [7:0] UPPER_FIRST = 8'd65;
    localparam logic [7:0] UPPER_LAST  = 8'd90;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] SPACE_CODE  = 8'd32;
    localparam logic [7:0] LOWER_A     = 8'd97;
    localparam logic [7:0] LOWER_Z     = 8'd122;
    localparam logic [7:0] DIGIT_0     = 8'd48;
    localparam logic [7:0] DIGIT_9     = 8'd57;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef logic [MAX_WORD_LEN-1:0][7:0] word_t;

    // classified byte travelling from front to back
    typedef struct packed {
        logic                   kept;
        logic [7:0]             lowered;
        logic [COUNT_WIDTH-1:0] letter_count;
        logic                   close;
        word_t                  word;
        logic [LEN_W-1:0]       len;
        logic                   trunc;
    } fe_item_t;

    // one word table row
    typedef struct packed {
        word_t                  word;
        logic [LEN_W-1:0]       len;
        logic [COUNT_WIDTH-1:0] count;
    } entry_t;

    // finished result
    typedef struct packed {
        logic                   kept;
        logic [7:0]             lowered;
        logic [COUNT_WIDTH-1:0] letter_count;
        logic                   done;
        logic [SLOT_W-1:0]      slot;
        logic [COUNT_WIDTH-1:0] occ;
        logic                   is_new;
        logic                   full;
        logic                   trunc;
    } res_t;

    typedef enum logic {
        B_IDLE,
        B_CMP
    } back_state_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        r = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
        return r;
    endfunction

endpackage

>>> rtl/lwfc_front.sv
module lwfc_front
    import lwfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_code,
    input  logic       last,
    input  logic       accept,
    output fe_item_t   item
);

    logic [COUNT_WIDTH-1:0] cnt_reg [LETTERS];
    word_t                  word_reg;
    logic [LEN_W-1:0]       len_reg;
    logic                   trunc_reg;

    logic [7:0]             lowered;
    logic [7:0]             diff;
    logic [LETTER_W-1:0]    li;
    logic                   is_letter;
    logic                   is_digit;
    logic                   is_space;
    logic                   append;
    logic                   can_add;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    word_t                  word_next;
    logic [LEN_W-1:0]       len_app;
    logic                   trunc_app;
    logic                   close;

    // lowering and classification
    always_comb
    begin
        lowered   = (char_code >= UPPER_FIRST && char_code <= UPPER_LAST) ?
                    char_code + CASE_OFFSET : char_code;
        is_letter = (lowered >= LOWER_A) && (lowered <= LOWER_Z);
        is_digit  = (lowered >= DIGIT_0) && (lowered <= DIGIT_9);
        is_space  = (lowered == SPACE_CODE);
        diff      = lowered - LOWER_A;
        li        = diff[LETTER_W-1:0];
        cnt_inc   = sat_inc(cnt_reg[li]);
    end

    // current word building
    always_comb
    begin
        append    = is_letter || is_digit;
        can_add   = len_reg < LEN_W'(MAX_WORD_LEN);
        word_next = word_reg;
        len_app   = len_reg;
        if (append && can_add)
        begin
            word_next[len_reg[POS_W-1:0]] = lowered;
            len_app = len_reg + 1'b1;
        end
        trunc_app = trunc_reg | (append & ~can_add);
        close     = (is_space || last) && (len_app != '0);
    end

    assign item.kept         = is_letter | is_digit | is_space;
    assign item.lowered      = lowered;
    assign item.letter_count = is_letter ? cnt_inc : '0;
    assign item.close        = close;
    assign item.word         = word_next;
    assign item.len          = len_app;
    assign item.trunc        = trunc_app;

    // letter counters and word state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LETTERS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            len_reg   <= '0;
            trunc_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (is_letter)
            begin
                cnt_reg[li] <= cnt_inc;
            end
            len_reg   <= close ? '0 : len_app;
            trunc_reg <= (close || last) ? 1'b0 : trunc_app;
        end
    end

    // word bytes carry no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

>>> rtl/lwfc_queue.sv
module lwfc_queue
    import lwfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  fe_item_t wr_item,
    output logic     full,
    input  logic     rd_en,
    output logic     empty,
    output fe_item_t head
);

    fe_item_t          slot_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg;
    logic [QPTR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_mem[rptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wptr_reg] <= wr_item;
        end
    end

endmodule

>>> rtl/lwfc_back.sv
module lwfc_back
    import lwfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_empty,
    input  fe_item_t q_head,
    output logic     q_pop,
    output res_t     res,
    output logic     res_valid,
    input  logic     res_pop
);

    entry_t            tbl_mem [TABLE_DEPTH];
    entry_t            rd_data_reg;
    back_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [USED_W-1:0] used_reg, used_next;
    fe_item_t          hold_reg;
    res_t              res_reg, res_next;
    logic              out_valid_reg;

    fe_item_t          cur;
    logic              out_free;
    logic              load_out;
    logic              load_hold;
    logic              match;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [SLOT_W-1:0] rd_addr;

    assign out_free = !out_valid_reg || res_pop;
    assign cur      = (state_reg == B_IDLE) ? q_head : hold_reg;

    // masked compare of stored row against the closed word
    always_comb
    begin
        match = (rd_data_reg.len == cur.len);
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            if ((LEN_W'(i) < cur.len) && (rd_data_reg.word[i] != cur.word[i]))
            begin
                match = 1'b0;
            end
        end
    end

    // lookup sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        used_next  = used_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        load_hold  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = used_reg[SLOT_W-1:0];
        wr_data    = '{word: cur.word, len: cur.len, count: COUNT_WIDTH'(1)};
        rd_addr    = '0;

        res_next              = '0;
        res_next.kept         = cur.kept;
        res_next.lowered      = cur.lowered;
        res_next.letter_count = cur.letter_count;
        res_next.done         = cur.close;
        res_next.trunc        = cur.close & cur.trunc;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop = 1'b1;
                    if (!q_head.close)
                    begin
                        load_out = 1'b1;
                    end
                    else if (used_reg == '0)
                    begin
                        load_out        = 1'b1;
                        wr_en           = 1'b1;
                        used_next       = used_reg + 1'b1;
                        res_next.slot   = '0;
                        res_next.occ    = COUNT_WIDTH'(1);
                        res_next.is_new = 1'b1;
                    end
                    else
                    begin
                        load_hold  = 1'b1;
                        idx_next   = '0;
                        state_next = B_CMP;
                    end
                end
            end
            B_CMP:
            begin
                rd_addr = idx_reg + 1'b1;
                if (match)
                begin
                    wr_en         = 1'b1;
                    wr_addr       = idx_reg;
                    wr_data       = rd_data_reg;
                    wr_data.count = sat_inc(rd_data_reg.count);
                    load_out      = 1'b1;
                    res_next.slot = idx_reg;
                    res_next.occ  = wr_data.count;
                    state_next    = B_IDLE;
                end
                else if ((USED_W'(idx_reg) + 1'b1) == used_reg)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                    if (used_reg < USED_W'(TABLE_DEPTH))
                    begin
                        wr_en           = 1'b1;
                        used_next       = used_reg + 1'b1;
                        res_next.slot   = used_reg[SLOT_W-1:0];
                        res_next.occ    = COUNT_WIDTH'(1);
                        res_next.is_new = 1'b1;
                    end
                    else
                    begin
                        res_next.full = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            idx_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            used_reg  <= used_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            res_reg <= res_next;
        end
        if (load_hold)
        begin
            hold_reg <= q_head;
        end
    end

    // word table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= tbl_mem[rd_addr];
    end

    assign res       = res_reg;
    assign res_valid = out_valid_reg;

    // search index stays inside the filled part of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CMP) |-> (USED_W'(idx_reg) < used_reg))
        else $error("search index beyond used entries");

    // fill count never passes the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USED_W'(TABLE_DEPTH))
        else $error("entry count overflow");

    // output register is free for the whole search
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CMP) |-> !out_valid_reg)
        else $error("result pending during search");

    // a new entry only grows the table by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> (used_reg == $past(used_reg) + 1'b1))
        else $error("entry count jumped");

endmodule

>>> rtl/letter_and_word_frequency_counter_unit.sv
// a byte that closes no word goes straight to the output register; a byte closing
// a word is compared from slot 0 up to the matching slot, or through all used entries
// on a miss, none when the table is empty; one table row is compared per cycle
// throughput: 1 byte per cycle outside word ends unless pop stalls; a 4-deep queue absorbs lookups
// reset: rst_n asynchronous active low clears letter counters, word state, table
// fill count and queue; table contents are not cleared and need no clearing pass
module letter_and_word_frequency_counter_unit
    import lwfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_code,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic        kept,
    output logic [7:0]  lowered_char,
    output logic [15:0] letter_count,
    output logic        word_done,
    output logic [5:0]  word_slot,
    output logic [15:0] word_occurrences,
    output logic        word_is_new,
    output logic        table_full,
    output logic        word_truncated
);

    fe_item_t fe_item;
    fe_item_t q_head;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    logic     accept;
    res_t     res;
    logic     res_valid;

    assign full   = q_full;
    assign accept = push && !q_full;

    // byte classification and word building
    lwfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_code),
        .last      (last),
        .accept    (accept),
        .item      (fe_item)
    );

    // decoupling queue
    lwfc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_item (fe_item),
        .full    (q_full),
        .rd_en   (q_pop),
        .empty   (q_empty),
        .head    (q_head)
    );

    // word table lookup
    lwfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res       (res),
        .res_valid (res_valid),
        .res_pop   (pop)
    );

    assign empty            = !res_valid;
    assign kept             = res.kept;
    assign lowered_char     = res.lowered;
    assign letter_count     = res.letter_count;
    assign word_done        = res.done;
    assign word_slot        = res.slot;
    assign word_occurrences = res.occ;
    assign word_is_new      = res.is_new;
    assign table_full       = res.full;
    assign word_truncated   = res.trunc;

endmodule
